// ----- design/hpid_pkg.sv -----
package hpid_pkg;

  localparam int HeadW   = 15;
  localparam int MaxPowW = 7;
  localparam int WaitW   = 16;
  localparam int GainW   = 24;
  localparam int ZoneW   = 15;
  localparam int LimW    = 23;
  localparam int TimeW   = 32;
  localparam int PowerW  = 8;
  localparam int ErrW    = 16;
  localparam int IsumW   = 24;
  localparam int DerW    = 17;
  localparam int PprodW  = GainW + 1 + ErrW;
  localparam int IprodW  = GainW + 1 + IsumW;
  localparam int DprodW  = GainW + 1 + DerW;
  localparam int SumW    = IprodW + 2;
  localparam int PowerShift = 22;

  localparam int AddrW   = 5;
  localparam int DataW   = 32;
  localparam int RegIdxW = 3;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [RegIdxW-1:0] REG_TARGET    = 3'd0;
  localparam logic [RegIdxW-1:0] REG_MAX_POWER = 3'd1;
  localparam logic [RegIdxW-1:0] REG_SETTLE    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_GAIN_P    = 3'd3;
  localparam logic [RegIdxW-1:0] REG_GAIN_I    = 3'd4;
  localparam logic [RegIdxW-1:0] REG_GAIN_D    = 3'd5;
  localparam logic [RegIdxW-1:0] REG_ZONE      = 3'd6;
  localparam logic [RegIdxW-1:0] REG_LIMIT     = 3'd7;

  localparam logic [HeadW-1:0]   RstTarget   = 15'd0;
  localparam logic [MaxPowW-1:0] RstMaxPower = 7'd127;
  localparam logic [WaitW-1:0]   RstSettle   = 16'd250;
  localparam logic [GainW-1:0]   RstGainP    = 24'd884736;
  localparam logic [GainW-1:0]   RstGainI    = 24'd655;
  localparam logic [GainW-1:0]   RstGainD    = 24'd2490368;
  localparam logic [ZoneW-1:0]   RstZone     = 15'd640;
  localparam logic [LimW-1:0]    RstLimit    = 23'd320000;

  localparam logic [HeadW-1:0] AngSettle   = 15'd640;
  localparam logic [HeadW-1:0] AngHalfTurn = 15'd11520;

  typedef struct packed {
    logic [HeadW-1:0]   target;
    logic [MaxPowW-1:0] max_power;
    logic [WaitW-1:0]   settle_wait;
    logic [GainW-1:0]   gain_p;
    logic [GainW-1:0]   gain_i;
    logic [GainW-1:0]   gain_d;
    logic [ZoneW-1:0]   zone;
    logic [LimW-1:0]    limit;
  } hpid_cfg_t;

  typedef struct packed {
    logic signed [PprodW-1:0] p_prod;
    logic signed [IprodW-1:0] i_prod;
    logic signed [DprodW-1:0] d_prod;
    logic                     flip;
    logic                     zero_pwr;
    logic                     done;
  } hpid_prod_t;

endpackage

// ----- design/hpid_in_if.sv -----
interface hpid_in_if
  import hpid_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [HeadW-1:0] heading;
  logic [TimeW-1:0] now_ms;

  modport source (output valid, cmd, heading, now_ms, input ready);
  modport sink (input valid, cmd, heading, now_ms, output ready);
endinterface

// ----- design/hpid_out_if.sv -----
interface hpid_out_if
  import hpid_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [PowerW-1:0] drive_power;
  logic                     done_res;

  modport source (output valid, drive_power, done_res, input ready);
  modport sink (input valid, drive_power, done_res, output ready);
endinterface

// ----- design/heading_pid_turn_controller.sv -----
// Turn-to-heading PID controller.
// in_ch carries one tick per beat: cmd (0 starts a new turn, 1 is a control
// tick), heading in 1/64 degree and now_ms. out_ch returns exactly one beat
// per input beat, in order: drive_power (signed, left side positive) and
// done_res. The APB port writes and reads eight registers at 4*i; write only
// while no tick is in flight.
// Three register stages (input, products, result) lie between an accepted
// tick and its result. Throughput: one tick per clock while out_ch takes
// results; the turn state updates between the input register and the
// product register, where the three gain products are formed in parallel,
// and they are summed, scaled and limited in the stage after.
// Reset clears all pipeline valids and the turn state and restores the
// register defaults. When out_ch stalls the result holds, each stage fills
// in turn, and in_ch.ready drops only once all three stages hold a beat.
module heading_pid_turn_controller
  import hpid_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  hpid_in_if.sink          in_ch,
  hpid_out_if.source       out_ch,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  hpid_cfg_t  cfg;
  hpid_prod_t prod;
  logic       prod_valid;
  logic       prod_ready;

  hpid_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hpid_update u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  hpid_power u_power (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod),
    .out_ch     (out_ch)
  );

endmodule

// ----- design/hpid_cfg.sv -----
module hpid_cfg
  import hpid_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output hpid_cfg_t        cfg
);

  hpid_cfg_t            cfg_r;
  hpid_cfg_t            cfg_nxt;
  logic [RegIdxW-1:0]   idx;
  logic                 wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_TARGET:    cfg_nxt.target      = pwdata[HeadW-1:0];
        REG_MAX_POWER: cfg_nxt.max_power   = pwdata[MaxPowW-1:0];
        REG_SETTLE:    cfg_nxt.settle_wait = pwdata[WaitW-1:0];
        REG_GAIN_P:    cfg_nxt.gain_p      = pwdata[GainW-1:0];
        REG_GAIN_I:    cfg_nxt.gain_i      = pwdata[GainW-1:0];
        REG_GAIN_D:    cfg_nxt.gain_d      = pwdata[GainW-1:0];
        REG_ZONE:      cfg_nxt.zone        = pwdata[ZoneW-1:0];
        REG_LIMIT:     cfg_nxt.limit       = pwdata[LimW-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TARGET:    prdata = DataW'(cfg_r.target);
      REG_MAX_POWER: prdata = DataW'(cfg_r.max_power);
      REG_SETTLE:    prdata = DataW'(cfg_r.settle_wait);
      REG_GAIN_P:    prdata = DataW'(cfg_r.gain_p);
      REG_GAIN_I:    prdata = DataW'(cfg_r.gain_i);
      REG_GAIN_D:    prdata = DataW'(cfg_r.gain_d);
      REG_ZONE:      prdata = DataW'(cfg_r.zone);
      REG_LIMIT:     prdata = DataW'(cfg_r.limit);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target      <= RstTarget;
      cfg_r.max_power   <= RstMaxPower;
      cfg_r.settle_wait <= RstSettle;
      cfg_r.gain_p      <= RstGainP;
      cfg_r.gain_i      <= RstGainI;
      cfg_r.gain_d      <= RstGainD;
      cfg_r.zone        <= RstZone;
      cfg_r.limit       <= RstLimit;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- design/hpid_update.sv -----
module hpid_update
  import hpid_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  hpid_cfg_t  cfg,
  hpid_in_if.sink    in_ch,
  output logic       prod_valid,
  input  logic       prod_ready,
  output hpid_prod_t prod
);

  logic             in_v_r;
  logic             cmd_r;
  logic [HeadW-1:0] heading_r;
  logic [TimeW-1:0] now_r;
  logic             prod_v_r;
  hpid_prod_t       prod_r;
  hpid_prod_t       prod_nxt;

  logic signed [IsumW-1:0] isum_r, isum_nxt;
  logic signed [ErrW-1:0]  prev_r, prev_nxt;
  logic                    flip_r, flip_nxt;
  logic                    settle_r, settle_nxt;
  logic [TimeW-1:0]        deadline_r, deadline_nxt;
  logic                    fin_r, fin_nxt;

  logic en_prod, en_in, go;

  logic signed [ErrW-1:0]  err;
  logic [ErrW-1:0]         mag16;
  logic [HeadW-1:0]        mag;
  logic                    in_zone;
  logic signed [IsumW:0]   isum_add, isum_pre, lim, isum_clamp;
  logic signed [IsumW-1:0] isum_new;
  logic signed [DerW-1:0]  deriv;
  logic                    flip_new;
  logic                    arm;
  logic [TimeW:0]          dsum;
  logic [TimeW-1:0]        deadline_new;
  logic                    settle_new;
  logic                    fin_new;

  assign en_prod     = !prod_v_r || prod_ready;
  assign en_in       = !in_v_r || en_prod;
  assign go          = in_v_r && en_prod;
  assign in_ch.ready = en_in;
  assign prod_valid  = prod_v_r;
  assign prod        = prod_r;

  assign err   = $signed({1'b0, cfg.target}) - $signed({1'b0, heading_r});
  assign mag16 = err[ErrW-1] ? ErrW'(-err) : err;
  assign mag   = mag16[HeadW-1:0];
  assign in_zone = (err != '0) && (mag < cfg.zone);

  assign isum_add = {isum_r[IsumW-1], isum_r}
                  + {{(IsumW+1-ErrW){err[ErrW-1]}}, err};
  assign isum_pre = in_zone ? isum_add : '0;
  assign lim      = $signed({2'b00, cfg.limit});

  always_comb begin
    if (isum_pre > lim) begin
      isum_clamp = lim;
    end else if (isum_pre < -lim) begin
      isum_clamp = -lim;
    end else begin
      isum_clamp = isum_pre;
    end
  end
  assign isum_new = isum_clamp[IsumW-1:0];

  assign deriv = (err == '0) ? '0 : ({err[ErrW-1], err} - {prev_r[ErrW-1], prev_r});

  assign flip_new = (mag > AngHalfTurn) ? 1'b1 : ((mag < AngHalfTurn) ? 1'b0 : flip_r);

  assign arm          = (mag < AngSettle) && !settle_r;
  assign dsum         = {1'b0, now_r} + (TimeW + 1)'(cfg.settle_wait);
  assign deadline_new = arm ? (dsum[TimeW] ? '1 : dsum[TimeW-1:0]) : deadline_r;
  assign settle_new   = settle_r || arm;
  assign fin_new      = settle_new && (now_r >= deadline_new);

  always_comb begin
    isum_nxt     = isum_r;
    prev_nxt     = prev_r;
    flip_nxt     = flip_r;
    settle_nxt   = settle_r;
    deadline_nxt = deadline_r;
    fin_nxt      = fin_r;
    prod_nxt.p_prod   = $signed({1'b0, cfg.gain_p}) * err;
    prod_nxt.i_prod   = $signed({1'b0, cfg.gain_i}) * isum_new;
    prod_nxt.d_prod   = $signed({1'b0, cfg.gain_d}) * deriv;
    prod_nxt.flip     = flip_new;
    prod_nxt.zero_pwr = 1'b1;
    prod_nxt.done     = 1'b0;
    if (go) begin
      if (cmd_r == CMD_START) begin
        isum_nxt     = '0;
        prev_nxt     = '0;
        flip_nxt     = 1'b0;
        settle_nxt   = 1'b0;
        deadline_nxt = '0;
        fin_nxt      = 1'b0;
      end else if (fin_r) begin
        prod_nxt.done = 1'b1;
      end else begin
        isum_nxt     = isum_new;
        prev_nxt     = err;
        flip_nxt     = flip_new;
        settle_nxt   = settle_new;
        deadline_nxt = deadline_new;
        fin_nxt      = fin_new;
        prod_nxt.zero_pwr = fin_new;
        prod_nxt.done     = fin_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      prod_v_r   <= 1'b0;
      isum_r     <= '0;
      prev_r     <= '0;
      flip_r     <= 1'b0;
      settle_r   <= 1'b0;
      deadline_r <= '0;
      fin_r      <= 1'b0;
    end else begin
      if (en_in) begin
        in_v_r <= in_ch.valid;
      end
      if (en_prod) begin
        prod_v_r <= in_v_r;
      end
      isum_r     <= isum_nxt;
      prev_r     <= prev_nxt;
      flip_r     <= flip_nxt;
      settle_r   <= settle_nxt;
      deadline_r <= deadline_nxt;
      fin_r      <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_in && in_ch.valid) begin
      cmd_r     <= in_ch.cmd;
      heading_r <= in_ch.heading;
      now_r     <= in_ch.now_ms;
    end
    if (go) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ----- design/hpid_power.sv -----
module hpid_power
  import hpid_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  hpid_cfg_t  cfg,
  input  logic       prod_valid,
  output logic       prod_ready,
  input  hpid_prod_t prod,
  hpid_out_if.source out_ch
);

  localparam int QW = SumW - PowerShift;

  logic                     out_v_r;
  logic signed [PowerW-1:0] power_r, power_nxt;
  logic                     done_r;
  logic                     en;

  logic signed [SumW-1:0] sum;
  logic [SumW-1:0]        abs_sum;
  logic [QW-1:0]          q;
  logic                   neg;
  logic                   over;
  logic [MaxPowW-1:0]     pmag;
  logic                   pneg;
  logic [PowerW-1:0]      pmag_ext;

  assign en         = !out_v_r || out_ch.ready;
  assign prod_ready = en;

  assign sum     = SumW'(prod.p_prod) + SumW'(prod.i_prod) + SumW'(prod.d_prod);
  assign neg     = sum[SumW-1];
  assign abs_sum = neg ? SumW'(-sum) : sum;
  assign q       = abs_sum[SumW-1:PowerShift];
  assign over    = q > QW'(cfg.max_power);
  assign pmag    = over ? cfg.max_power : q[MaxPowW-1:0];
  assign pneg    = over ? (neg ^ prod.flip) : neg;
  assign pmag_ext = {1'b0, pmag};

  always_comb begin
    if (prod.zero_pwr) begin
      power_nxt = '0;
    end else if (pneg) begin
      power_nxt = $signed(PowerW'(-pmag_ext));
    end else begin
      power_nxt = $signed(pmag_ext);
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.drive_power = power_r;
  assign out_ch.done_res    = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && prod_valid) begin
      power_r <= power_nxt;
      done_r  <= prod.done;
    end
  end

endmodule

// ----- design/hpid_checker.sv -----
module hpid_checker
  import hpid_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [PowerW-1:0] drive_power,
  input logic                     done_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> drive_power == '0)
    else $error("power not zero on finished turn");

  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> drive_power != 8'sh80)
    else $error("power out of range");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result stage");

endmodule

bind heading_pid_turn_controller hpid_checker u_hpid_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .drive_power (out_ch.drive_power),
  .done_res    (out_ch.done_res)
);

// ----- bench/tb_top.sv -----
module tb_top;
  import hpid_pkg::*;

  typedef struct packed {
    logic signed [PowerW-1:0] power;
    logic                     done;
  } turn_result_t;

  typedef struct packed {
    logic             cmd;
    logic [HeadW-1:0] heading;
    logic [TimeW-1:0] now_ms;
    logic             typed;
    turn_result_t     res;
  } tick_row_t;

  typedef enum int {SET_MAXED, SET_ZEROED, SET_TYPICAL, SET_WILD} setting_kind_t;

  localparam int   WatchdogLimit = 2000;
  localparam int   HoldCycles    = 80;
  localparam int   TicksPerPhase = 250;
  localparam int   NumPhases     = 8;

  logic             clk;
  logic             rst_n;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  hpid_in_if  in_ch ();
  hpid_out_if out_ch ();

  heading_pid_turn_controller dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // register copy and turn state of the controller
  hpid_cfg_t    gains;
  int           integ_acc;
  int           last_err;
  logic         flip_dir;
  logic         settling;
  logic [TimeW-1:0] deadline;
  logic         turn_over;

  turn_result_t pending_drive_q[$];
  tick_row_t    dir_rows[$];

  int  errors;
  int  ticks_sent;
  int  phase_ticks;
  int  turns_done;
  int  settings_used;
  int  idle_cycles;
  int  rx_wait;
  int  hold_left;
  bit  hold_req;
  bit  tx_idle_on;
  bit  rx_idle_on;
  bit  reset_done;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_turn_state();
    integ_acc = 0;
    last_err  = 0;
    flip_dir  = 1'b0;
    settling  = 1'b0;
    deadline  = '0;
    turn_over = 1'b0;
  endfunction

  function automatic turn_result_t step_heading_pid(input logic cmd,
                                                    input logic [HeadW-1:0] heading,
                                                    input logic [TimeW-1:0] now);
    turn_result_t r;
    int           err;
    int           mag;
    int           deriv;
    int           lim;
    longint       acc;
    longint       pw;
    longint       mp;
    logic [TimeW:0] dl;
    r = '0;
    if (cmd == CMD_START) begin
      clear_turn_state();
      return r;
    end
    if (turn_over) begin
      r.done = 1'b1;
      return r;
    end
    err = int'(gains.target) - int'(heading);
    mag = (err < 0) ? -err : err;
    if (err != 0 && mag < int'(gains.zone)) integ_acc = integ_acc + err;
    else integ_acc = 0;
    lim = int'(gains.limit);
    if (integ_acc > lim) integ_acc = lim;
    else if (integ_acc < -lim) integ_acc = -lim;
    deriv = err - last_err;
    last_err = err;
    if (err == 0) deriv = 0;
    acc = longint'(gains.gain_p) * longint'(err) + longint'(gains.gain_i) * longint'(integ_acc)
        + longint'(gains.gain_d) * longint'(deriv);
    if (acc >= 0) pw = acc >>> PowerShift;
    else pw = -((-acc) >>> PowerShift);
    if (mag > int'(AngHalfTurn)) flip_dir = 1'b1;
    else if (mag < int'(AngHalfTurn)) flip_dir = 1'b0;
    mp = longint'(gains.max_power);
    if (pw > mp) pw = flip_dir ? -mp : mp;
    else if (pw < -mp) pw = flip_dir ? mp : -mp;
    if (mag < int'(AngSettle) && !settling) begin
      dl = {1'b0, now} + (TimeW + 1)'(gains.settle_wait);
      settling = 1'b1;
      deadline = dl[TimeW] ? '1 : dl[TimeW-1:0];
    end
    if (settling && now >= deadline) begin
      turn_over = 1'b1;
      r.done = 1'b1;
      return r;
    end
    r.power = pw[PowerW-1:0];
    return r;
  endfunction

  function automatic tick_row_t row(input logic cmd, input int heading, input logic [TimeW-1:0] now,
                                    input logic typed, input int power, input logic done);
    tick_row_t t;
    t.cmd       = cmd;
    t.heading   = heading[HeadW-1:0];
    t.now_ms    = now;
    t.typed     = typed;
    t.res.power = power[PowerW-1:0];
    t.res.done  = done;
    return t;
  endfunction

  task automatic send_tick(input logic cmd, input logic [HeadW-1:0] heading,
                           input logic [TimeW-1:0] now, input logic typed,
                           input turn_result_t typed_res);
    int           gap;
    turn_result_t r;
    gap = tx_idle_on ? $urandom_range(0, 6) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.cmd     = cmd;
    in_ch.heading = heading;
    in_ch.now_ms  = now;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    r = step_heading_pid(cmd, heading, now);
    if (typed) r = typed_res;
    pending_drive_q.push_back(r);
    ticks_sent++;
    phase_ticks++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_drive_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [RegIdxW-1:0] idx, input logic [DataW-1:0] val);
    logic [DataW-1:0] held;
    held = '0;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    case (idx)
      REG_TARGET: begin
        gains.target = val[HeadW-1:0];
        held = DataW'(gains.target);
      end
      REG_MAX_POWER: begin
        gains.max_power = val[MaxPowW-1:0];
        held = DataW'(gains.max_power);
      end
      REG_SETTLE: begin
        gains.settle_wait = val[WaitW-1:0];
        held = DataW'(gains.settle_wait);
      end
      REG_GAIN_P: begin
        gains.gain_p = val[GainW-1:0];
        held = DataW'(gains.gain_p);
      end
      REG_GAIN_I: begin
        gains.gain_i = val[GainW-1:0];
        held = DataW'(gains.gain_i);
      end
      REG_GAIN_D: begin
        gains.gain_d = val[GainW-1:0];
        held = DataW'(gains.gain_d);
      end
      REG_ZONE: begin
        gains.zone = val[ZoneW-1:0];
        held = DataW'(gains.zone);
      end
      REG_LIMIT: begin
        gains.limit = val[LimW-1:0];
        held = DataW'(gains.limit);
      end
      default: ;
    endcase
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    if (prdata !== held) begin
      $error("prdata reg %0d: expected %0h, got %0h", idx, held, prdata);
      errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic program_setting(input setting_kind_t kind);
    logic [DataW-1:0] v[8];
    case (kind)
      SET_MAXED: begin
        v = '{32'h7FFF, 32'h7F, 32'hFFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF,
              32'h7FFF, 32'h7F_FFFF};
      end
      SET_ZEROED: begin
        v = '{default: 32'h0};
      end
      SET_TYPICAL: begin
        v[0] = $urandom_range(0, 23039);
        v[1] = $urandom_range(1, 127);
        v[2] = $urandom_range(0, 400);
        v[3] = $urandom_range(0, 2000000);
        v[4] = $urandom_range(0, 20000);
        v[5] = $urandom_range(0, 4000000);
        v[6] = $urandom_range(0, 2000);
        v[7] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3000) : $urandom_range(0, 400000);
      end
      default: begin
        foreach (v[i]) v[i] = $urandom;
      end
    endcase
    cfg_write(REG_TARGET,    v[0]);
    cfg_write(REG_MAX_POWER, v[1]);
    cfg_write(REG_SETTLE,    v[2]);
    cfg_write(REG_GAIN_P,    v[3]);
    cfg_write(REG_GAIN_I,    v[4]);
    cfg_write(REG_GAIN_D,    v[5]);
    cfg_write(REG_ZONE,      v[6]);
    cfg_write(REG_LIMIT,     v[7]);
    settings_used++;
  endtask

  // result side: stall draw per beat, plus one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    rx_wait      = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = reset_done;
      end
    end
  end

  always @(posedge clk) begin
    turn_result_t want;
    if (out_ch.valid && out_ch.ready) begin
      rx_wait = rx_idle_on ? $urandom_range(0, 6) : 0;
      if (out_ch.done_res === 1'b1) turns_done++;
      if (pending_drive_q.size() == 0) begin
        $error("unexpected result beat: drive_power %0d done_res %0b",
               out_ch.drive_power, out_ch.done_res);
        errors++;
      end else begin
        want = pending_drive_q.pop_front();
        if (out_ch.drive_power !== want.power) begin
          $error("drive_power: expected %0d, got %0d", want.power, out_ch.drive_power);
          errors++;
        end
        if (out_ch.done_res !== want.done) begin
          $error("done_res: expected %0b, got %0b", want.done, out_ch.done_res);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!reset_done || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    setting_kind_t    plan[NumPhases];
    logic [TimeW-1:0] now;
    int               h;
    int               tgt;
    int               n;
    int               div;
    int               jitter;
    int               step;
    turn_result_t     none;
    bit               hold_issued;

    clk           = 1'b0;
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_START;
    in_ch.heading = '0;
    in_ch.now_ms  = '0;
    errors        = 0;
    ticks_sent    = 0;
    phase_ticks   = 0;
    turns_done    = 0;
    settings_used = 1;
    idle_cycles   = 0;
    hold_req      = 1'b0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    reset_done    = 1'b0;
    none          = '0;
    hold_issued   = 1'b0;

    gains.target      = RstTarget;
    gains.max_power   = RstMaxPower;
    gains.settle_wait = RstSettle;
    gains.gain_p      = RstGainP;
    gains.gain_i      = RstGainI;
    gains.gain_d      = RstGainD;
    gains.zone        = RstZone;
    gains.limit       = RstLimit;
    clear_turn_state();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n      = 1'b1;
    reset_done = 1'b1;

    // reset settings: target 0, max power 127, settle 250 ms, zone 10 deg
    dir_rows.push_back(row(CMD_START, 0,     32'd0,          1, 0,    0));
    dir_rows.push_back(row(CMD_TICK,  23039, 32'd1000,       1, 127,  0));
    dir_rows.push_back(row(CMD_TICK,  11520, 32'd1020,       0, 0,    0));
    dir_rows.push_back(row(CMD_TICK,  11519, 32'd1040,       0, 0,    0));
    dir_rows.push_back(row(CMD_TICK,  32767, 32'd1060,       0, 0,    0));
    dir_rows.push_back(row(CMD_TICK,  0,     32'd1080,       1, 0,    0));
    dir_rows.push_back(row(CMD_TICK,  600,   32'd1100,       0, 0,    0));
    dir_rows.push_back(row(CMD_TICK,  639,   32'd1200,       0, 0,    0));
    dir_rows.push_back(row(CMD_TICK,  5,     32'd1330,       1, 0,    1));
    dir_rows.push_back(row(CMD_TICK,  20000, 32'd5000,       1, 0,    1));
    dir_rows.push_back(row(CMD_START, 100,   32'd0,          1, 0,    0));
    dir_rows.push_back(row(CMD_TICK,  640,   32'd100,        0, 0,    0));
    dir_rows.push_back(row(CMD_TICK,  1,     32'hFFFF_FF80,  0, 0,    0));
    dir_rows.push_back(row(CMD_TICK,  0,     32'hFFFF_FFFE,  1, 0,    0));
    dir_rows.push_back(row(CMD_TICK,  2,     32'hFFFF_FFFF,  1, 0,    1));
    dir_rows.push_back(row(CMD_START, 32767, 32'hFFFF_FFFF,  1, 0,    0));
    dir_rows.push_back(row(CMD_TICK,  32767, 32'd0,          0, 0,    0));
    dir_rows.push_back(row(CMD_TICK,  1,     32'd20,         0, 0,    0));
    dir_rows.push_back(row(CMD_TICK,  320,   32'd40,         0, 0,    0));
    dir_rows.push_back(row(CMD_TICK,  16384, 32'd60,         0, 0,    0));
    foreach (dir_rows[i])
      send_tick(dir_rows[i].cmd, dir_rows[i].heading, dir_rows[i].now_ms,
                dir_rows[i].typed, dir_rows[i].res);

    plan = '{SET_TYPICAL, SET_MAXED, SET_TYPICAL, SET_ZEROED, SET_TYPICAL, SET_WILD,
             SET_TYPICAL, SET_TYPICAL};

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph != 0) begin
        drain_results();
        program_setting(plan[ph]);
      end
      tx_idle_on  = (ph % 3 != 1);
      rx_idle_on  = (ph % 4 != 2);
      phase_ticks = 0;
      hold_issued = 1'b0;
      while (phase_ticks < TicksPerPhase) begin
        if ($urandom_range(0, 4) == 0) begin
          send_tick(1'($urandom_range(0, 1)), HeadW'($urandom), $urandom, 0, none);
        end else begin
          tgt = int'(gains.target);
          h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 23039);
          now = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom;
          send_tick(CMD_START, HeadW'(h), now, 0, none);
          n = $urandom_range(4, 40);
          for (int k = 0; k < n; k++) begin
            div    = $urandom_range(2, 5);
            jitter = int'($urandom_range(0, 40)) - 20;
            h = h + (tgt - h) / div + jitter;
            if ($urandom_range(0, 9) == 0) h = tgt;
            if (h < 0) h = 0;
            if (h > 32767) h = 32767;
            case ($urandom_range(0, 9))
              0:       step = 0;
              1, 2:    step = $urandom_range(0, 5000);
              default: step = 20;
            endcase
            now = now + step;
            send_tick(CMD_TICK, HeadW'(h), now, 0, none);
            if ((ph == 2 || ph == 5) && phase_ticks >= 50 && !hold_issued) begin
              hold_req    = 1'b1;
              hold_issued = 1'b1;
            end
          end
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d ticks under %0d register settings, %0d done results seen",
             ticks_sent, settings_used, turns_done);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
